// File: rtl/inode_cache_refcount_table_macros.svh
// Assertion macros for the inode cache refcount table.
// Included by the top level; uses its clock and reset ports.
`ifndef INODE_CACHE_REFCOUNT_TABLE_MACROS_SVH
`define INODE_CACHE_REFCOUNT_TABLE_MACROS_SVH

// same-cycle implication
`define ICRT_ASSERT_IMPLY(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("icrt assertion failed");

// next-cycle implication
`define ICRT_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("icrt assertion failed");

`endif

// File: rtl/icrt_pkg.sv
// Shared types, constants and helper functions of the inode cache refcount table.
// No dependencies.
package icrt_pkg;

   localparam int SLOTS    = 64;
   localparam int IDX_W    = $clog2(SLOTS);
   localparam int CNT_W    = $clog2(SLOTS + 1);
   localparam int IPB_LOG2 = 3;
   localparam int INODES_PER_BLOCK = 1 << IPB_LOG2;

   localparam int DEV_W    = 4;
   localparam int INO_W    = 16;
   localparam int SLOT_W   = 6;
   localparam int START_W  = 24;
   localparam int BLK_W    = 25;
   localparam int OFF_W    = 3;
   localparam int REFS_W   = 8;
   localparam int STATUS_W = 3;

   localparam logic [REFS_W-1:0] REFS_MAX = '1;

   // item kinds on req_kind
   localparam logic KIND_GET = 1'b0;
   localparam logic KIND_PUT = 1'b1;

   typedef enum logic [STATUS_W-1:0] {
      ST_HIT       = 3'd0,
      ST_LOADED    = 3'd1,
      ST_FULL      = 3'd2,
      ST_RELEASED  = 3'd3,
      ST_WRITEBACK = 3'd4,
      ST_UNDERFLOW = 3'd5
   } status_type;

   typedef struct packed {
      logic               valid;
      logic [DEV_W-1:0]   device;
      logic [INO_W-1:0]   inode;
      logic [REFS_W-1:0]  refs;
      logic               dirty;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // outcome of one lookup pass over the table
   typedef struct packed {
      logic              hit;
      logic [IDX_W-1:0]  hit_idx;
      entry_type         hit_entry;
      logic              free;
      logic [IDX_W-1:0]  free_idx;
   } scan_status_type;

   typedef struct packed {
      logic [BLK_W-1:0] blk;
      logic [OFF_W-1:0] off;
   } locate_type;

   // on-disk position of an inode; inode zero wraps to the last entry
   function automatic locate_type locate(logic [INO_W-1:0] ino, logic [START_W-1:0] start);
      logic [INO_W-1:0] n;
      logic [INO_W-1:0] q;
      logic [INO_W-1:0] r;
      locate_type       res;
      n = ino - INO_W'(1);
      q = n >> IPB_LOG2;
      r = n & INO_W'(INODES_PER_BLOCK - 1);
      res.blk = BLK_W'(q) + BLK_W'(start);
      res.off = r[OFF_W-1:0];
      return res;
   endfunction

   function automatic logic [SLOT_W-1:0] to_slot(logic [IDX_W-1:0] i);
      logic [IDX_W+SLOT_W-1:0] w;
      w = {{SLOT_W{1'b0}}, i};
      return w[SLOT_W-1:0];
   endfunction

   function automatic logic [IDX_W-1:0] to_idx(logic [SLOT_W-1:0] s);
      logic [IDX_W+SLOT_W-1:0] w;
      w = {{IDX_W{1'b0}}, s};
      return w[IDX_W-1:0];
   endfunction

   function automatic logic in_table(logic [SLOT_W-1:0] s);
      logic [31:0] w;
      w = 32'(s);
      return w < 32'(SLOTS);
   endfunction

endpackage

// File: rtl/icrt_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module icrt_ram #(
   parameter int WIDTH = 30,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/icrt_scan.sv
// Lookup tracker: watches the entries streamed out of the slot memory and keeps
// the first key match and the first zero-count slot. Depends on icrt_pkg.
module icrt_scan (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          clear,
   input  logic                          beat_valid,
   input  logic [icrt_pkg::IDX_W-1:0]    beat_idx,
   input  icrt_pkg::entry_type           beat_entry,
   input  logic [icrt_pkg::DEV_W-1:0]    key_device,
   input  logic [icrt_pkg::INO_W-1:0]    key_inode,
   output icrt_pkg::scan_status_type     scan
);

   icrt_pkg::scan_status_type scan_ff;
   logic                      match;
   logic                      empty;

   assign match = beat_entry.valid && (beat_entry.device == key_device)
                  && (beat_entry.inode == key_inode);
   assign empty = (beat_entry.refs == '0);

   always_ff @(posedge clock) begin
      if (reset || clear) begin
         scan_ff.hit  <= 1'b0;
         scan_ff.free <= 1'b0;
      end else if (beat_valid && !scan_ff.hit) begin
         if (match) begin
            scan_ff.hit       <= 1'b1;
            scan_ff.hit_idx   <= beat_idx;
            scan_ff.hit_entry <= beat_entry;
         end
         if (empty && !scan_ff.free) begin
            scan_ff.free     <= 1'b1;
            scan_ff.free_idx <= beat_idx;
         end
      end
   end

   assign scan = scan_ff;

endmodule

// File: rtl/inode_cache_refcount_table.sv
// Inode cache refcount table: top level with sequencer, slot memory and result register.
// Depends on icrt_pkg, icrt_ram, icrt_scan and inode_cache_refcount_table_macros.svh.
//
// A table of SLOTS in-memory inode slots keyed by (device, inode number), held
// in one slot memory with one read and one write port. One item is worked on at
// a time. A get (kind 0) walks the whole table through the read port, one slot
// per cycle, remembering the first key match and the first slot with a zero
// count; it ends early on a match. A hit raises the count (saturating at 255);
// a miss claims the lowest free slot and reports the inode's disk block and
// offset; no free slot gives table full. A put (kind 1) reads one slot, lowers
// its count, optionally marks it dirty, and reports a writeback when a dirty
// slot drops to zero; a put to a zero-count slot gives underflow. How long a
// get takes is set by the table walk through the single memory read port, and
// it ends sooner on an early hit; a put reads only the one named slot.
// A finished result sits in the output register, and the next item is taken
// while it waits; the next result is only loaded once that register is free.
// Slots never written since reset read as all zero through a per-slot written
// flag, so no clearing pass is needed. The inode table start register may be
// written at any time the block is idle; csr_ready is always high.
`include "inode_cache_refcount_table_macros.svh"

module inode_cache_refcount_table (
   input  logic                             clock,
   input  logic                             reset,
   // configuration write
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [icrt_pkg::START_W-1:0]     csr_inode_table_start,
   // request items
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic                             req_kind,
   input  logic [icrt_pkg::DEV_W-1:0]       req_device,
   input  logic [icrt_pkg::INO_W-1:0]       req_inode_number,
   input  logic [icrt_pkg::SLOT_W-1:0]      req_slot_index,
   input  logic                             req_mark_dirty,
   // response items
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [icrt_pkg::STATUS_W-1:0]    rsp_status,
   output logic [icrt_pkg::SLOT_W-1:0]      rsp_slot,
   output logic [icrt_pkg::BLK_W-1:0]       rsp_disk_block,
   output logic [icrt_pkg::OFF_W-1:0]       rsp_block_offset,
   output logic [icrt_pkg::REFS_W-1:0]      rsp_ref_count
);

   typedef enum logic [2:0] {
      IDLE,
      SCAN,
      GET_DONE,
      PUT_RD,
      PUT_DONE
   } state_type;

   state_type                         state_ff;

   // latched item
   logic                              kind_ff;
   logic [icrt_pkg::DEV_W-1:0]        dev_ff;
   logic [icrt_pkg::INO_W-1:0]        ino_ff;
   logic [icrt_pkg::SLOT_W-1:0]       idx_ff;
   logic                              dirty_ff;

   logic [icrt_pkg::START_W-1:0]      start_ff;

   // table walk
   logic [icrt_pkg::CNT_W-1:0]        cnt_ff;
   logic                              beat_ff;
   logic [icrt_pkg::IDX_W-1:0]        beat_idx_ff;

   // written flags, one per slot
   logic [icrt_pkg::SLOTS-1:0]        written_ff;
   logic                              rd_written_ff;

   // result register
   logic                              rsp_valid_ff;
   logic [icrt_pkg::STATUS_W-1:0]     rsp_status_ff;
   logic [icrt_pkg::SLOT_W-1:0]       rsp_slot_ff;
   logic [icrt_pkg::BLK_W-1:0]        rsp_disk_block_ff;
   logic [icrt_pkg::OFF_W-1:0]        rsp_block_offset_ff;
   logic [icrt_pkg::REFS_W-1:0]       rsp_ref_count_ff;

   logic                              req_accept;
   logic                              out_free;
   logic                              finish;
   logic                              scan_more;
   logic                              scan_done;

   logic [icrt_pkg::IDX_W-1:0]        rd_addr;
   logic [icrt_pkg::ENTRY_W-1:0]      rd_data;
   icrt_pkg::entry_type               rd_entry;

   icrt_pkg::scan_status_type         scan;

   // result of the finishing cycle
   logic                              wr_en;
   logic [icrt_pkg::IDX_W-1:0]        wr_addr;
   icrt_pkg::entry_type               wr_entry;
   icrt_pkg::status_type              res_status;
   logic [icrt_pkg::SLOT_W-1:0]       res_slot;
   logic [icrt_pkg::REFS_W-1:0]       res_refs;
   logic                              res_locate;
   logic [icrt_pkg::INO_W-1:0]        loc_ino;
   icrt_pkg::locate_type              loc;
   logic                              put_dirty;
   logic [icrt_pkg::REFS_W-1:0]       put_refs;

   // terms for the checks at the end
   logic                              hit_key_ok;
   logic                              rsp_loaded;
   logic                              rsp_failed;

   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != IDLE);
   assign req_accept = req_valid && !req_stall;
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign finish     = ((state_ff == GET_DONE) || (state_ff == PUT_DONE)) && out_free;

   // walk issues one address per cycle until the end or a hit
   assign scan_more = (state_ff == SCAN) && (cnt_ff < icrt_pkg::CNT_W'(icrt_pkg::SLOTS))
                      && !scan.hit;
   assign scan_done = scan.hit
                      || ((cnt_ff == icrt_pkg::CNT_W'(icrt_pkg::SLOTS)) && !beat_ff);

   assign rd_addr  = (kind_ff == icrt_pkg::KIND_PUT) ? icrt_pkg::to_idx(idx_ff)
                                                     : cnt_ff[icrt_pkg::IDX_W-1:0];
   assign rd_entry = rd_written_ff ? icrt_pkg::entry_type'(rd_data) : '0;

   icrt_ram #(
      .WIDTH (icrt_pkg::ENTRY_W),
      .DEPTH (icrt_pkg::SLOTS)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_entry),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   icrt_scan u_scan (
      .clock      (clock),
      .reset      (reset),
      .clear      (req_accept),
      .beat_valid (beat_ff),
      .beat_idx   (beat_idx_ff),
      .beat_entry (rd_entry),
      .key_device (dev_ff),
      .key_inode  (ino_ff),
      .scan       (scan)
   );

   // put arithmetic on the slot read back
   assign put_dirty = rd_entry.dirty || dirty_ff;
   assign put_refs  = rd_entry.refs - icrt_pkg::REFS_W'(1);

   assign loc_ino = (state_ff == PUT_DONE) ? rd_entry.inode : ino_ff;
   assign loc     = icrt_pkg::locate(loc_ino, start_ff);

   always_comb begin
      wr_en      = 1'b0;
      wr_addr    = scan.hit_idx;
      wr_entry   = scan.hit_entry;
      res_status = icrt_pkg::ST_FULL;
      res_slot   = '0;
      res_refs   = '0;
      res_locate = 1'b0;
      if (state_ff == GET_DONE) begin
         if (scan.hit) begin
            wr_en         = finish;
            if (scan.hit_entry.refs != icrt_pkg::REFS_MAX) begin
               wr_entry.refs = scan.hit_entry.refs + icrt_pkg::REFS_W'(1);
            end
            res_status    = icrt_pkg::ST_HIT;
            res_slot      = icrt_pkg::to_slot(scan.hit_idx);
            res_refs      = wr_entry.refs;
         end else if (scan.free) begin
            // claim the lowest zero-count slot
            wr_en           = finish;
            wr_addr         = scan.free_idx;
            wr_entry.valid  = 1'b1;
            wr_entry.device = dev_ff;
            wr_entry.inode  = ino_ff;
            wr_entry.refs   = icrt_pkg::REFS_W'(1);
            wr_entry.dirty  = 1'b0;
            res_status      = icrt_pkg::ST_LOADED;
            res_slot        = icrt_pkg::to_slot(scan.free_idx);
            res_refs        = icrt_pkg::REFS_W'(1);
            res_locate      = 1'b1;
         end
      end else begin
         wr_addr  = icrt_pkg::to_idx(idx_ff);
         wr_entry = rd_entry;
         res_slot = idx_ff;
         if (!icrt_pkg::in_table(idx_ff) || (rd_entry.refs == '0)) begin
            res_status = icrt_pkg::ST_UNDERFLOW;
         end else begin
            wr_en         = finish;
            wr_entry.refs = put_refs;
            res_refs      = put_refs;
            if ((put_refs == '0) && put_dirty) begin
               // last reference to a modified inode: write it back
               wr_entry.dirty = 1'b0;
               res_status     = icrt_pkg::ST_WRITEBACK;
               res_locate     = 1'b1;
            end else begin
               wr_entry.dirty = put_dirty;
               res_status     = icrt_pkg::ST_RELEASED;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= IDLE;
         kind_ff       <= icrt_pkg::KIND_GET;
         start_ff      <= '0;
         cnt_ff        <= '0;
         beat_ff       <= 1'b0;
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (csr_valid && csr_ready) begin
            start_ff <= csr_inode_table_start;
         end

         rd_written_ff <= written_ff[rd_addr];
         beat_ff       <= scan_more;
         beat_idx_ff   <= cnt_ff[icrt_pkg::IDX_W-1:0];

         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end

         // a finishing item reloads the register in the same cycle
         if (rsp_valid_ff && !rsp_stall && !finish) begin
            rsp_valid_ff <= 1'b0;
         end

         case (state_ff)
            IDLE: begin
               if (req_accept) begin
                  kind_ff  <= req_kind;
                  dev_ff   <= req_device;
                  ino_ff   <= req_inode_number;
                  idx_ff   <= req_slot_index;
                  dirty_ff <= req_mark_dirty;
                  cnt_ff   <= '0;
                  state_ff <= (req_kind == icrt_pkg::KIND_PUT) ? PUT_RD : SCAN;
               end
            end
            SCAN: begin
               if (scan_more) begin
                  cnt_ff <= cnt_ff + icrt_pkg::CNT_W'(1);
               end
               if (scan_done) begin
                  state_ff <= GET_DONE;
               end
            end
            PUT_RD: begin
               state_ff <= PUT_DONE;
            end
            GET_DONE, PUT_DONE: begin
               if (finish) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_status_ff       <= res_status;
                  rsp_slot_ff         <= res_slot;
                  rsp_ref_count_ff    <= res_refs;
                  rsp_disk_block_ff   <= res_locate ? loc.blk : '0;
                  rsp_block_offset_ff <= res_locate ? loc.off : '0;
                  state_ff            <= IDLE;
               end
            end
            default: begin
               state_ff <= IDLE;
            end
         endcase
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_slot         = rsp_slot_ff;
   assign rsp_disk_block   = rsp_disk_block_ff;
   assign rsp_block_offset = rsp_block_offset_ff;
   assign rsp_ref_count    = rsp_ref_count_ff;

   assign hit_key_ok = scan.hit_entry.valid && (scan.hit_entry.device == dev_ff)
                       && (scan.hit_entry.inode == ino_ff);
   assign rsp_loaded = rsp_valid_ff && (rsp_status_ff == icrt_pkg::ST_LOADED);
   assign rsp_failed = rsp_valid_ff && ((rsp_status_ff == icrt_pkg::ST_FULL)
                       || (rsp_status_ff == icrt_pkg::ST_UNDERFLOW));

   // a recorded hit really carries the key of the item being looked up
   `ICRT_ASSERT_IMPLY(a_hit_key, (state_ff == GET_DONE) && scan.hit, hit_key_ok)

   // a freshly loaded slot always starts with one reference
   `ICRT_ASSERT_IMPLY(a_load_one, rsp_loaded, rsp_ref_count_ff == icrt_pkg::REFS_W'(1))

   // full and underflow results carry no count and no disk position
   `ICRT_ASSERT_IMPLY(a_fail_zero, rsp_failed, ~|{rsp_ref_count_ff, rsp_disk_block_ff})

   // a slot written by a finishing item is flagged as written afterwards
   `ICRT_ASSERT_NEXT(a_written, wr_en, written_ff[$past(wr_addr)])

endmodule
